[rtl/core/sbrt_pkg.sv]
// Shared types and constants of the subband router and precision tracker.
package sbrt_pkg;

  localparam int SUBBAND_SIZE_DEF = 64;
  localparam int COEFF_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int POS_W      = 7;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = 6;
  localparam int PREC_W     = 7;
  localparam int OFFSET_W   = 6;
  localparam int MANT_W     = 11;
  localparam int EXP_W      = 7;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 11;
  localparam int NUM_BANDS  = 4;

  localparam logic REQ_COEFF  = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic KIND_COEFF = 1'b0;
  localparam logic KIND_PARAM = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_LL_OFFSET   = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HL_OFFSET   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LH_OFFSET   = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HH_OFFSET   = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LL_MANTISSA = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_HL_MANTISSA = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LH_MANTISSA = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_HH_MANTISSA = 4'd7;

  typedef enum logic [1:0] {
    BAND_LL = 2'd0,
    BAND_HL = 2'd1,
    BAND_LH = 2'd2,
    BAND_HH = 2'd3
  } sbrt_band_t;

  // classified request as it travels from front end to back end
  typedef struct packed {
    logic                     finish;
    sbrt_band_t               band;
    logic signed [PREC_W-1:0] prec;
  } sbrt_ctrl_t;

  typedef struct packed {
    logic [NUM_BANDS-1:0][OFFSET_W-1:0] step_offset;
    logic [NUM_BANDS-1:0][MANT_W-1:0]   step_mantissa;
  } sbrt_cfg_t;

endpackage

[rtl/core/sbrt_cfg.sv]
// Step offset and mantissa register file.
module sbrt_cfg
  import sbrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output sbrt_cfg_t             cfg_regs
);

  sbrt_cfg_t regs_r;
  sbrt_cfg_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_LL_OFFSET:   regs_nxt.step_offset[BAND_LL]   = cfg_data[OFFSET_W-1:0];
        REG_HL_OFFSET:   regs_nxt.step_offset[BAND_HL]   = cfg_data[OFFSET_W-1:0];
        REG_LH_OFFSET:   regs_nxt.step_offset[BAND_LH]   = cfg_data[OFFSET_W-1:0];
        REG_HH_OFFSET:   regs_nxt.step_offset[BAND_HH]   = cfg_data[OFFSET_W-1:0];
        REG_LL_MANTISSA: regs_nxt.step_mantissa[BAND_LL] = cfg_data[MANT_W-1:0];
        REG_HL_MANTISSA: regs_nxt.step_mantissa[BAND_HL] = cfg_data[MANT_W-1:0];
        REG_LH_MANTISSA: regs_nxt.step_mantissa[BAND_LH] = cfg_data[MANT_W-1:0];
        REG_HH_MANTISSA: regs_nxt.step_mantissa[BAND_HH] = cfg_data[MANT_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_regs = regs_r;

endmodule

[rtl/core/sbrt_front.sv]
// Front end: accepts requests, picks the subband and derives magnitude and precision.
module sbrt_front
  import sbrt_pkg::*;
#(
  parameter int SUBBAND_SIZE = SUBBAND_SIZE_DEF,
  parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [POS_W-1:0]          in_x_pos,
  input  logic [POS_W-1:0]          in_y_pos,
  input  logic signed [VALUE_W-1:0] in_coeff_value,
  output logic                      q_push,
  input  logic                      q_full,
  output sbrt_ctrl_t                q_ctrl,
  output logic [VALUE_W-1:0]        q_value,
  output logic [COEFF_WIDTH-1:0]    q_mag
);

  localparam int BL_W = $clog2(COEFF_WIDTH + 1);

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic                   s1_finish_r;
  sbrt_band_t             s1_band_r;
  logic [VALUE_W-1:0]     s1_value_r;
  logic [COEFF_WIDTH-1:0] s1_mag_r;

  logic                   accept;
  logic                   x_low;
  logic                   y_low;
  sbrt_band_t             band;
  logic [COEFF_WIDTH-1:0] coeff;
  logic [COEFF_WIDTH-1:0] mag;
  logic [BL_W-1:0]        bit_len;
  logic [7:0]             prec_ext;
  logic signed [PREC_W-1:0] prec;

  assign in_ready = !s1_valid_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = s1_valid_r && !q_full;

  assign x_low = 32'(in_x_pos) < 32'(SUBBAND_SIZE);
  assign y_low = 32'(in_y_pos) < 32'(SUBBAND_SIZE);

  always_comb begin
    case ({y_low, x_low})
      2'b11:   band = BAND_LL;
      2'b10:   band = BAND_HL;
      2'b01:   band = BAND_LH;
      default: band = BAND_HH;
    endcase
  end

  // most negative value maps to 2^(COEFF_WIDTH-1), unsigned
  assign coeff = COEFF_WIDTH'($unsigned(in_coeff_value));
  assign mag   = coeff[COEFF_WIDTH-1] ? (~coeff + COEFF_WIDTH'(1)) : coeff;

  assign s1_valid_nxt = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_finish_r <= (in_req_type == REQ_FINISH);
      s1_band_r   <= band;
      s1_value_r  <= $unsigned(in_coeff_value);
      s1_mag_r    <= mag;
    end
  end

  // precision = ceil(log2 mag) - 1 = bit_length - is_pow2 - 1; 0 for zero magnitude
  always_comb begin
    bit_len = '0;
    for (int i = 0; i < COEFF_WIDTH; i++) begin
      if (s1_mag_r[i]) bit_len = BL_W'(i + 1);
    end
  end

  assign prec_ext = 8'(bit_len) - 8'($onehot(s1_mag_r)) - 8'd1;
  assign prec     = (s1_mag_r == '0) ? '0 : $signed(prec_ext[PREC_W-1:0]);

  assign q_ctrl.finish = s1_finish_r;
  assign q_ctrl.band   = s1_band_r;
  assign q_ctrl.prec   = prec;
  assign q_value       = s1_value_r;
  assign q_mag         = s1_mag_r;

endmodule

[rtl/core/sbrt_queue.sv]
// Small register queue between front end and back end.
module sbrt_queue
  import sbrt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/core/sbrt_back.sv]
// Back end: fill counters, running maxima, parameter sequencing and output register.
module sbrt_back
  import sbrt_pkg::*;
#(
  parameter int SUBBAND_SIZE = SUBBAND_SIZE_DEF,
  parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  sbrt_ctrl_t                q_ctrl,
  input  logic [VALUE_W-1:0]        q_value,
  input  logic [COEFF_WIDTH-1:0]    q_mag,
  output logic                      q_pop,
  input  sbrt_cfg_t                 cfg_regs,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [1:0]                out_band,
  output logic [IDX_W-1:0]          out_row,
  output logic [IDX_W-1:0]          out_col,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_band_full,
  output logic signed [EXP_W-1:0]   out_exponent,
  output logic [MANT_W-1:0]         out_mantissa,
  output logic                      out_last
);

  localparam int CNT_W = $clog2(SUBBAND_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUBBAND_SIZE - 1);

  logic [CNT_W-1:0]         row_r    [NUM_BANDS];
  logic [CNT_W-1:0]         row_nxt  [NUM_BANDS];
  logic [CNT_W-1:0]         col_r    [NUM_BANDS];
  logic [CNT_W-1:0]         col_nxt  [NUM_BANDS];
  logic [COEFF_WIDTH-1:0]   max_r    [NUM_BANDS];
  logic [COEFF_WIDTH-1:0]   max_nxt  [NUM_BANDS];
  logic signed [PREC_W-1:0] prec_r   [NUM_BANDS];
  logic signed [PREC_W-1:0] prec_nxt [NUM_BANDS];
  logic [1:0]               fin_idx_r;
  logic [1:0]               fin_idx_nxt;

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      out_kind_r;
  logic                      out_kind_nxt;
  logic [1:0]                out_band_r;
  logic [1:0]                out_band_nxt;
  logic [IDX_W-1:0]          out_row_r;
  logic [IDX_W-1:0]          out_row_nxt;
  logic [IDX_W-1:0]          out_col_r;
  logic [IDX_W-1:0]          out_col_nxt;
  logic [VALUE_W-1:0]        out_value_r;
  logic [VALUE_W-1:0]        out_value_nxt;
  logic                      out_band_full_r;
  logic                      out_band_full_nxt;
  logic [EXP_W-1:0]          out_exponent_r;
  logic [EXP_W-1:0]          out_exponent_nxt;
  logic [MANT_W-1:0]         out_mantissa_r;
  logic [MANT_W-1:0]         out_mantissa_nxt;
  logic                      out_last_r;
  logic                      out_last_nxt;

  logic                      advance;
  logic                      work;
  logic [1:0]                b;
  logic [CNT_W-1:0]          cur_row;
  logic [CNT_W-1:0]          cur_col;
  logic signed [7:0]         exp_wide;
  logic [EXP_W-1:0]          exp_sat;
  logic [OFFSET_W-1:0]       sel_offset;
  logic signed [PREC_W-1:0]  sel_prec;

  assign advance = !out_valid_r || out_ready;
  assign work    = advance && !q_empty;
  assign b       = q_ctrl.band;
  assign cur_row = row_r[b];
  assign cur_col = col_r[b];

  assign sel_offset = cfg_regs.step_offset[fin_idx_r];
  assign sel_prec   = prec_r[fin_idx_r];
  assign exp_wide   = 8'({sel_prec[PREC_W-1], sel_prec})
                    - 8'({{2{sel_offset[OFFSET_W-1]}}, sel_offset});

  always_comb begin
    if (exp_wide > 8'sd63) begin
      exp_sat = 7'h3f;
    end else if (exp_wide < -8'sd64) begin
      exp_sat = 7'h40;
    end else begin
      exp_sat = exp_wide[EXP_W-1:0];
    end
  end

  always_comb begin
    row_nxt           = row_r;
    col_nxt           = col_r;
    max_nxt           = max_r;
    prec_nxt          = prec_r;
    fin_idx_nxt       = fin_idx_r;
    q_pop             = 1'b0;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_kind_nxt      = out_kind_r;
    out_band_nxt      = out_band_r;
    out_row_nxt       = out_row_r;
    out_col_nxt       = out_col_r;
    out_value_nxt     = out_value_r;
    out_band_full_nxt = out_band_full_r;
    out_exponent_nxt  = out_exponent_r;
    out_mantissa_nxt  = out_mantissa_r;
    out_last_nxt      = out_last_r;
    if (work) begin
      out_valid_nxt = 1'b1;
      if (q_ctrl.finish) begin
        // one parameter result per cycle while the output is not stalled, bands in order
        out_kind_nxt      = KIND_PARAM;
        out_band_nxt      = fin_idx_r;
        out_row_nxt       = '0;
        out_col_nxt       = '0;
        out_value_nxt     = '0;
        out_band_full_nxt = 1'b0;
        out_exponent_nxt  = exp_sat;
        out_mantissa_nxt  = cfg_regs.step_mantissa[fin_idx_r];
        out_last_nxt      = (fin_idx_r == 2'(BAND_HH));
        if (fin_idx_r == 2'(BAND_HH)) begin
          q_pop       = 1'b1;
          fin_idx_nxt = '0;
          for (int i = 0; i < NUM_BANDS; i++) begin
            row_nxt[i]  = '0;
            col_nxt[i]  = '0;
            max_nxt[i]  = '0;
            prec_nxt[i] = '0;
          end
        end else begin
          fin_idx_nxt = fin_idx_r + 2'd1;
        end
      end else begin
        q_pop             = 1'b1;
        out_kind_nxt      = KIND_COEFF;
        out_band_nxt      = b;
        out_row_nxt       = IDX_W'(cur_row);
        out_col_nxt       = IDX_W'(cur_col);
        out_value_nxt     = q_value;
        out_band_full_nxt = (cur_row == CNT_LAST) && (cur_col == CNT_LAST);
        out_exponent_nxt  = '0;
        out_mantissa_nxt  = '0;
        out_last_nxt      = 1'b1;
        if (q_mag > max_r[b]) begin
          max_nxt[b]  = q_mag;
          prec_nxt[b] = q_ctrl.prec;
        end
        if (cur_col == CNT_LAST) begin
          col_nxt[b] = '0;
          row_nxt[b] = (cur_row == CNT_LAST) ? '0 : cur_row + CNT_W'(1);
        end else begin
          col_nxt[b] = cur_col + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fin_idx_r   <= '0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        row_r[i]  <= '0;
        col_r[i]  <= '0;
        max_r[i]  <= '0;
        prec_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      fin_idx_r   <= fin_idx_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      max_r       <= max_nxt;
      prec_r      <= prec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r      <= out_kind_nxt;
    out_band_r      <= out_band_nxt;
    out_row_r       <= out_row_nxt;
    out_col_r       <= out_col_nxt;
    out_value_r     <= out_value_nxt;
    out_band_full_r <= out_band_full_nxt;
    out_exponent_r  <= out_exponent_nxt;
    out_mantissa_r  <= out_mantissa_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_band      = out_band_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = $signed(out_value_r);
  assign out_band_full = out_band_full_r;
  assign out_exponent  = $signed(out_exponent_r);
  assign out_mantissa  = out_mantissa_r;
  assign out_last      = out_last_r;

endmodule

[rtl/core/subband_router_and_precision_tracker.sv]
// An accepted request passes the front end register, the queue and the output register.
// Throughput: one coefficient request per cycle while out_ready does not stall the output.
// A finish request holds the back end until it has given one parameter result per band.
// The front end keeps accepting into a queue of QUEUE_DEPTH entries meanwhile.
// Reset (synchronous, rst_n low) clears step registers, counters, maxima and the queue.
// No clearing pass after reset: the block takes requests once rst_n is released.
module subband_router_and_precision_tracker
  import sbrt_pkg::*;
#(
  parameter int SUBBAND_SIZE = SUBBAND_SIZE_DEF,
  parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [POS_W-1:0]          in_x_pos,
  input  logic [POS_W-1:0]          in_y_pos,
  input  logic signed [VALUE_W-1:0] in_coeff_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [1:0]                out_band,
  output logic [IDX_W-1:0]          out_row,
  output logic [IDX_W-1:0]          out_col,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_band_full,
  output logic signed [EXP_W-1:0]   out_exponent,
  output logic [MANT_W-1:0]         out_mantissa,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_ADDR_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int CTRL_W = $bits(sbrt_ctrl_t);
  localparam int Q_W    = CTRL_W + VALUE_W + COEFF_WIDTH;

  sbrt_cfg_t              cfg_regs;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  sbrt_ctrl_t             fe_ctrl;
  logic [VALUE_W-1:0]     fe_value;
  logic [COEFF_WIDTH-1:0] fe_mag;
  logic [Q_W-1:0]         q_wdata;
  logic [Q_W-1:0]         q_rdata;
  sbrt_ctrl_t             be_ctrl;
  logic [VALUE_W-1:0]     be_value;
  logic [COEFF_WIDTH-1:0] be_mag;

  assign cfg_ready = 1'b1;

  sbrt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_regs  (cfg_regs)
  );

  sbrt_front #(
    .SUBBAND_SIZE (SUBBAND_SIZE),
    .COEFF_WIDTH  (COEFF_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_coeff_value (in_coeff_value),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_ctrl         (fe_ctrl),
    .q_value        (fe_value),
    .q_mag          (fe_mag)
  );

  assign q_wdata = {fe_ctrl, fe_value, fe_mag};

  sbrt_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign be_ctrl  = sbrt_ctrl_t'(q_rdata[Q_W-1 -: CTRL_W]);
  assign be_value = q_rdata[COEFF_WIDTH +: VALUE_W];
  assign be_mag   = q_rdata[COEFF_WIDTH-1:0];

  sbrt_back #(
    .SUBBAND_SIZE (SUBBAND_SIZE),
    .COEFF_WIDTH  (COEFF_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_ctrl        (be_ctrl),
    .q_value       (be_value),
    .q_mag         (be_mag),
    .q_pop         (q_pop),
    .cfg_regs      (cfg_regs),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_band      (out_band),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_band_full (out_band_full),
    .out_exponent  (out_exponent),
    .out_mantissa  (out_mantissa),
    .out_last      (out_last)
  );

endmodule

[rtl/core/sbrt_checker.sv]
// Port-level checks of the subband router, bound to the top level.
module sbrt_checker
  import sbrt_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_kind,
  input logic [1:0]                out_band,
  input logic [IDX_W-1:0]          out_row,
  input logic [IDX_W-1:0]          out_col,
  input logic signed [VALUE_W-1:0] out_value,
  input logic                      out_band_full,
  input logic signed [EXP_W-1:0]   out_exponent,
  input logic [MANT_W-1:0]         out_mantissa,
  input logic                      out_last
);

  // a stalled result stays valid and keeps its kind, band, value and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_band) && $stable(out_value)
                                && $stable(out_kind) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_coeff_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_COEFF |-> out_last && out_exponent == '0
                                            && out_mantissa == '0)
    else $error("coefficient result carries parameter fields");

  a_param_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PARAM |-> (out_last == (out_band == 2'(BAND_HH)))
                                            && out_row == '0 && out_col == '0
                                            && !out_band_full)
    else $error("parameter result with wrong last or coefficient fields");

  // parameter results of one finish request come back to back, bands in order
  a_param_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_PARAM && !out_last
      |=> out_valid && out_kind == KIND_PARAM && out_band == $past(out_band) + 2'd1)
    else $error("parameter results out of sequence");

endmodule

bind subband_router_and_precision_tracker sbrt_checker u_sbrt_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the subband router and precision tracker.
module tb_top;
  import sbrt_pkg::*;

  typedef struct packed {
    logic                 kind;
    logic [1:0]           band;
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic [VALUE_W-1:0]   value;
    logic                 band_full;
    logic [EXP_W-1:0]     exponent;
    logic [MANT_W-1:0]    mantissa;
    logic                 last;
  } band_result_t;

  // Tracks step registers, fill counters and band peaks; holds expected results in order.
  class subband_scoreboard;
    logic [OFFSET_W-1:0] step_off[NUM_BANDS];
    logic [MANT_W-1:0]   step_mant[NUM_BANDS];
    logic [IDX_W-1:0]    row_cnt[NUM_BANDS];
    logic [IDX_W-1:0]    col_cnt[NUM_BANDS];
    logic [VALUE_W-1:0]  peak[NUM_BANDS];
    band_result_t        expected_q[$];
    int                  errors;

    function new();
      errors = 0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        step_off[b] = '0;
        step_mant[b] = '0;
      end
      clear_tile();
    endfunction

    function void clear_tile();
      for (int b = 0; b < NUM_BANDS; b++) begin
        row_cnt[b] = '0;
        col_cnt[b] = '0;
        peak[b] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx <= REG_HH_OFFSET)
        step_off[idx - REG_LL_OFFSET] = data[OFFSET_W-1:0];
      else if (idx <= REG_HH_MANTISSA)
        step_mant[idx - REG_LL_MANTISSA] = data[MANT_W-1:0];
    endfunction

    // ceil(log2(m)) - 1, or 0 for an empty band
    function int band_precision(logic [VALUE_W-1:0] m);
      logic [VALUE_W-1:0] v;
      int n;
      if (m == '0) return 0;
      v = m - 1;
      n = 0;
      while (v != '0) begin
        v = v >> 1;
        n++;
      end
      return n - 1;
    endfunction

    function void note_request(logic req, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                               logic [VALUE_W-1:0] v);
      band_result_t r;
      logic [1:0] b;
      logic [VALUE_W-1:0] mag;
      int off;
      int e;
      if (req == REQ_FINISH) begin
        for (int k = 0; k < NUM_BANDS; k++) begin
          off = int'($signed(step_off[k]));
          e = band_precision(peak[k]) - off;
          if (e > 63) e = 63;
          if (e < -64) e = -64;
          r = '0;
          r.kind = KIND_PARAM;
          r.band = k[1:0];
          r.exponent = e[EXP_W-1:0];
          r.mantissa = step_mant[k];
          r.last = (k == NUM_BANDS - 1);
          expected_q.push_back(r);
        end
        clear_tile();
      end else begin
        b[0] = (x >= SUBBAND_SIZE_DEF);
        b[1] = (y >= SUBBAND_SIZE_DEF);
        mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
        if (mag > peak[b]) peak[b] = mag;
        r = '0;
        r.kind = KIND_COEFF;
        r.band = b;
        r.row = row_cnt[b];
        r.col = col_cnt[b];
        r.value = v;
        r.band_full = (row_cnt[b] == SUBBAND_SIZE_DEF - 1) &&
                      (col_cnt[b] == SUBBAND_SIZE_DEF - 1);
        r.last = 1'b1;
        expected_q.push_back(r);
        if (col_cnt[b] == SUBBAND_SIZE_DEF - 1) begin
          col_cnt[b] = '0;
          row_cnt[b] = (row_cnt[b] == SUBBAND_SIZE_DEF - 1) ? '0 : row_cnt[b] + 1'b1;
        end else begin
          col_cnt[b] = col_cnt[b] + 1'b1;
        end
      end
    endfunction

    function void check_field(string name, logic [VALUE_W-1:0] expv, logic [VALUE_W-1:0] got);
      if (got !== expv) begin
        $error("%s mismatch: expected %0h, got %0h", name, expv, got);
        errors++;
      end
    endfunction

    function void check_result(band_result_t got);
      band_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: band %0d kind %0d", got.band, got.kind);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("band", want.band, got.band);
      check_field("row", want.row, got.row);
      check_field("col", want.col, got.col);
      check_field("value", want.value, got.value);
      check_field("band_full", want.band_full, got.band_full);
      check_field("exponent", want.exponent, got.exponent);
      check_field("mantissa", want.mantissa, got.mantissa);
      check_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_COEFF;
  logic [POS_W-1:0]      in_x_pos = '0;
  logic [POS_W-1:0]      in_y_pos = '0;
  logic [VALUE_W-1:0]    in_coeff_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_kind;
  logic [1:0]            out_band;
  logic [IDX_W-1:0]      out_row;
  logic [IDX_W-1:0]      out_col;
  logic [VALUE_W-1:0]    out_value;
  logic                  out_band_full;
  logic [EXP_W-1:0]      out_exponent;
  logic [MANT_W-1:0]     out_mantissa;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 37;
  int recv_idle_pct = 57;

  subband_scoreboard sb = new();

  subband_router_and_precision_tracker DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_coeff_value (in_coeff_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_band       (out_band),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_band_full  (out_band_full),
    .out_exponent   (out_exponent),
    .out_mantissa   (out_mantissa),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        sb.note_request(in_req_type, in_x_pos, in_y_pos, in_coeff_value);
      if (out_valid && out_ready)
        sb.check_result({out_kind, out_band, out_row, out_col, out_value, out_band_full,
                         out_exponent, out_mantissa, out_last});
    end
  end

  // all driver tasks start and end on a falling edge
  task automatic push_request(input logic req, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_x_pos <= x;
    in_y_pos <= y;
    in_coeff_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic push_coeff(input sbrt_band_t b, input logic [VALUE_W-1:0] v);
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    x = POS_W'((b[0] ? SUBBAND_SIZE_DEF : 0) + $urandom_range(SUBBAND_SIZE_DEF - 1));
    y = POS_W'((b[1] ? SUBBAND_SIZE_DEF : 0) + $urandom_range(SUBBAND_SIZE_DEF - 1));
    push_request(REQ_COEFF, x, y, v);
  endtask

  task automatic push_finish();
    push_request(REQ_FINISH, POS_W'($urandom), POS_W'($urandom), VALUE_W'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // program all step registers, then one write to an unused index
  task automatic load_steps(input bit pick_random, input logic [CFG_DATA_W-1:0] off_data,
                            input logic [CFG_DATA_W-1:0] mant_data);
    for (int b = 0; b < NUM_BANDS; b++) begin
      write_reg(CFG_ADDR_W'(REG_LL_OFFSET + b),
                pick_random ? CFG_DATA_W'($urandom) : off_data);
      write_reg(CFG_ADDR_W'(REG_LL_MANTISSA + b),
                pick_random ? CFG_DATA_W'($urandom) : mant_data);
    end
    write_reg(CFG_ADDR_W'(REG_HH_MANTISSA + $urandom_range(1, 8)), CFG_DATA_W'($urandom));
  endtask

  function automatic logic [VALUE_W-1:0] pick_coeff();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return $urandom_range(1) ? -$urandom_range(16) : $urandom_range(16);
      5: return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_tile(input int n_coeff);
    sbrt_band_t hot;
    hot = sbrt_band_t'($urandom_range(3));
    for (int i = 0; i < n_coeff; i++)
      push_coeff($urandom_range(1) ? hot : sbrt_band_t'($urandom_range(3)), pick_coeff());
    push_finish();
  endtask

  task automatic short_extreme_tile();
    push_coeff(BAND_LL, 32'h8000_0000);
    push_coeff(BAND_HL, 32'h1);
    push_coeff(BAND_LH, 32'h0);
    push_finish();
  endtask

  initial begin
    int sent;
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners, sign extremes and quadrant edges at reset register values
    push_request(REQ_COEFF, 7'd0, 7'd0, 32'h0);
    push_request(REQ_COEFF, 7'd127, 7'd0, 32'h7fff_ffff);
    push_request(REQ_COEFF, 7'd0, 7'd127, 32'h8000_0000);
    push_request(REQ_COEFF, 7'd127, 7'd127, 32'hffff_ffff);
    push_request(REQ_COEFF, 7'd63, 7'd63, 32'h1);
    push_request(REQ_COEFF, 7'd64, 7'd63, 32'h2);
    push_request(REQ_COEFF, 7'd63, 7'd64, 32'h3);
    push_request(REQ_COEFF, 7'd64, 7'd64, 32'hffff_fffd);
    push_request(REQ_COEFF, 7'h55, 7'h2a, 32'h5555_5555);
    push_request(REQ_COEFF, 7'h2a, 7'h55, 32'haaaa_aaaa);
    push_request(REQ_FINISH, 7'd127, 7'd127, 32'hffff_ffff);
    push_request(REQ_FINISH, 7'd0, 7'd0, 32'h0);
    // peak of one gives precision -1
    push_request(REQ_COEFF, 7'd1, 7'd1, 32'h1);
    push_request(REQ_FINISH, 7'd0, 7'd0, 32'h0);
    wait_idle();

    // largest positive offset, full mantissa; upper data bits must be dropped
    load_steps(1'b0, 11'h7df, 11'h7ff);
    short_extreme_tile();
    wait_idle();
    load_steps(1'b0, 11'h020, 11'h000);
    short_extreme_tile();
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 37; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      load_steps(1'b1, '0, '0);
      sent = 0;
      while (sent < 65) begin
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
        run_tile(n);
        sent += n + 1;
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_top failed");
    $finish;
  end

endmodule

[subband_router_and_precision_tracker.f]
rtl/core/sbrt_pkg.sv
rtl/core/sbrt_cfg.sv
rtl/core/sbrt_front.sv
rtl/core/sbrt_queue.sv
rtl/core/sbrt_back.sv
rtl/core/subband_router_and_precision_tracker.sv
rtl/core/sbrt_checker.sv
tb/tb_top.sv
